// File: hdl/sith_pkg.sv
// Shared types, codes and hash helpers for the string intern hash table.
// No dependencies; imported by every module of the block but sith_mod.
package sith_pkg;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;

    localparam logic [2:0] ST_NEW   = 3'd0;
    localparam logic [2:0] ST_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_LONG  = 3'd4;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       last_byte;
        logic       empty_name;
    } t_req;

    typedef struct packed {
        logic [9:0] name_index;
        logic [2:0] status;
    } t_rsp;

    function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * HASH_PRIME;
    endfunction

endpackage

// File: hdl/sith_mod.sv
// Slot index unit: hash reduced to a slot number by masking and registered.
// The user keeps SLOT_COUNT a power of two (unchecked); depends only on its parameter.
module sith_mod #(
    parameter int SLOT_COUNT = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [31:0]                   i_hash,
    output logic                          o_done,
    output logic [$clog2(SLOT_COUNT)-1:0] o_rem
);
    localparam int SW = $clog2(SLOT_COUNT);

    logic          r_done;
    logic [SW-1:0] r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        if (i_start) begin
            r_rem <= i_hash[SW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// File: hdl/string_intern_hash_table_core.sv
// Top level: byte intake with FNV-1a fold, slot probing sequencer, name memories.
// Depends on sith_pkg and sith_mod. Non-final bytes: one request per cycle, busy stays low.
// Empty and over-long names answer in the cycle after the request. A final byte of a name
// within the limit holds busy through the slot computation, each probe, length check,
// byte compare and byte copy on insert; the result shows in the first cycle with busy low.
// Reset clears the slot table with busy high; the receiver cannot stall.
module string_intern_hash_table_core #(
    parameter int CAPACITY       = 1024,
    parameter int SLOT_COUNT     = 2048,
    parameter int MAX_NAME_BYTES = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  sith_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_valid,
    output sith_pkg::t_rsp  o_rsp
);
    import sith_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int PW = $clog2(SLOT_COUNT + 1);
    localparam logic [8:0] MAXL = 9'(MAX_NAME_BYTES);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_MOD      = 11'b00000000100,
        S_SLOT_RD  = 11'b00000001000,
        S_SLOT_CHK = 11'b00000010000,
        S_LEN_RD   = 11'b00000100000,
        S_LEN_CHK  = 11'b00001000000,
        S_CMP_RD   = 11'b00010000000,
        S_CMP_CHK  = 11'b00100000000,
        S_WR_RD    = 11'b01000000000,
        S_WR_WR    = 11'b10000000000
    } t_state;

    logic [7:0]    mem_pend  [256];
    logic [7:0]    mem_store [CAPACITY*256];
    logic [7:0]    mem_len   [CAPACITY];
    logic [IW-1:0] mem_slot  [SLOT_COUNT];

    t_state        r_state, n_state;
    logic [31:0]   r_hash, n_hash;
    logic [8:0]    r_plen, n_plen;
    logic [CW-1:0] r_entry, n_entry;
    logic [SW-1:0] r_slot, n_slot;
    logic [PW-1:0] r_probes, n_probes;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_cnt, n_cnt;
    logic          r_valid, n_valid;
    t_rsp          r_rsp, n_rsp;

    logic [7:0]    r_pend_q, r_store_q, r_len_q;
    logic [IW-1:0] r_slot_q;

    logic          w_acc, w_mod_start, w_mod_done;
    logic [31:0]   w_fold;
    logic [SW-1:0] w_rem, w_slot_nx;
    logic          w_slot_we;
    logic [SW-1:0] w_slot_wa;
    logic [IW-1:0] w_slot_wd;
    logic          w_store_we, w_len_we;
    logic [IW-1:0] w_row;
    logic [7:0]    w_pend_ra;

    sith_mod #(.SLOT_COUNT(SLOT_COUNT)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_hash  (w_fold),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    assign busy      = (r_state != S_IDLE);
    assign w_acc     = start && !busy;
    assign w_fold    = fnv_fold(r_hash, i_req.name_byte);
    assign w_slot_nx = (r_slot == SW'(SLOT_COUNT - 1)) ? '0 : r_slot + SW'(1);
    assign w_row     = (r_state == S_WR_WR || r_state == S_WR_RD) ? r_entry[IW-1:0] : r_idx;
    assign w_pend_ra = r_cnt;

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_plen      = r_plen;
        n_entry     = r_entry;
        n_slot      = r_slot;
        n_probes    = r_probes;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_valid     = 1'b0;
        n_rsp       = r_rsp;
        w_mod_start = 1'b0;
        w_slot_we   = 1'b0;
        w_slot_wa   = r_slot;
        w_slot_wd   = r_entry[IW-1:0];
        w_store_we  = 1'b0;
        w_len_we    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_slot_we = 1'b1;
                w_slot_wa = r_slot;
                w_slot_wd = '0;
                n_slot    = w_slot_nx;
                if (r_slot == SW'(SLOT_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_acc) begin
                    if (i_req.empty_name) begin
                        n_valid = 1'b1;
                        n_rsp   = '{name_index: 10'd0, status: ST_EMPTY};
                        n_hash  = HASH_BASIS;
                        n_plen  = 9'd0;
                    end else begin
                        n_hash = w_fold;
                        n_plen = (r_plen < MAXL) ? r_plen + 9'd1 : MAXL + 9'd1;
                        if (i_req.last_byte) begin
                            if (r_plen >= MAXL) begin
                                n_valid = 1'b1;
                                n_rsp   = '{name_index: 10'd0, status: ST_LONG};
                                n_hash  = HASH_BASIS;
                                n_plen  = 9'd0;
                            end else begin
                                w_mod_start = 1'b1;
                                n_state     = S_MOD;
                            end
                        end
                    end
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_slot   = w_rem;
                    n_probes = '0;
                    n_state  = S_SLOT_RD;
                end
            end
            S_SLOT_RD: n_state = S_SLOT_CHK;
            S_SLOT_CHK: begin
                if (r_slot_q == '0) begin
                    if (r_entry >= CW'(CAPACITY)) begin
                        n_valid = 1'b1;
                        n_rsp   = '{name_index: 10'd0, status: ST_FULL};
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = 8'd0;
                        n_state = S_WR_RD;
                    end
                end else begin
                    n_idx   = r_slot_q;
                    n_state = S_LEN_RD;
                end
            end
            S_LEN_RD: n_state = S_LEN_CHK;
            S_LEN_CHK: begin
                n_cnt   = 8'd0;
                n_state = (r_len_q == r_plen[7:0]) ? S_CMP_RD : S_SLOT_CHK;
            end
            S_CMP_RD: n_state = S_CMP_CHK;
            S_CMP_CHK: begin
                if (r_store_q != r_pend_q) begin
                    n_state = S_SLOT_CHK;
                end else if ({1'b0, r_cnt} == r_plen - 9'd1) begin
                    n_valid = 1'b1;
                    n_rsp   = '{name_index: 10'(r_idx), status: ST_FOUND};
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 8'd1;
                    n_state = S_CMP_RD;
                end
            end
            S_WR_RD: n_state = S_WR_WR;
            S_WR_WR: begin
                w_store_we = 1'b1;
                if ({1'b0, r_cnt} == r_plen - 9'd1) begin
                    w_len_we  = 1'b1;
                    w_slot_we = 1'b1;
                    n_entry   = r_entry + CW'(1);
                    n_valid   = 1'b1;
                    n_rsp     = '{name_index: 10'(r_entry), status: ST_NEW};
                    n_state   = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 8'd1;
                    n_state = S_WR_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if ((r_state == S_LEN_CHK && r_len_q != r_plen[7:0]) ||
            (r_state == S_CMP_CHK && r_store_q != r_pend_q)) begin
            if (r_probes + PW'(1) == PW'(SLOT_COUNT)) begin
                n_valid = 1'b1;
                n_rsp   = '{name_index: 10'd0, status: ST_FULL};
                n_state = S_IDLE;
            end else begin
                n_probes = r_probes + PW'(1);
                n_slot   = w_slot_nx;
                n_state  = S_SLOT_RD;
            end
        end
        if (n_valid && r_state != S_IDLE) begin
            n_hash = HASH_BASIS;
            n_plen = 9'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_hash  <= HASH_BASIS;
            r_plen  <= 9'd0;
            r_entry <= CW'(1);
            r_slot  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            r_plen  <= n_plen;
            r_entry <= n_entry;
            r_slot  <= n_slot;
            r_valid <= n_valid;
        end
        r_probes <= n_probes;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_rsp    <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !i_req.empty_name && r_plen < MAXL) begin
            mem_pend[r_plen[7:0]] <= i_req.name_byte;
        end
        r_pend_q <= mem_pend[w_pend_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_store_we) mem_store[{w_row, r_cnt}] <= r_pend_q;
        r_store_q <= mem_store[{w_row, r_cnt}];
    end

    always_ff @(posedge i_clk) begin
        if (w_len_we) mem_len[r_entry[IW-1:0]] <= r_plen[7:0];
        r_len_q <= mem_len[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) mem_slot[w_slot_wa] <= w_slot_wd;
        r_slot_q <= mem_slot[r_slot];
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;
endmodule

// File: hdl/sith_checker.sv
// Port-level checks for the string intern hash table core, with its bind.
// Depends on sith_pkg and string_intern_hash_table_core.
module sith_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input sith_pkg::t_req i_req,
    input logic           o_valid,
    input sith_pkg::t_rsp o_rsp
);
    import sith_pkg::*;

    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.empty_name) |=> (o_valid && o_rsp.status == ST_EMPTY))
        else $error("empty name not answered next cycle");

    a_mid_byte_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_req.empty_name && !i_req.last_byte) |=> !o_valid)
        else $error("result after a non-final byte");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == ST_FULL || o_rsp.status == ST_EMPTY ||
                     o_rsp.status == ST_LONG)) |-> (o_rsp.name_index == 10'd0))
        else $error("nonzero index with failure status");

    a_index_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == ST_NEW || o_rsp.status == ST_FOUND))
            |-> (o_rsp.name_index != 10'd0))
        else $error("zero index with new or found status");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");
endmodule

bind string_intern_hash_table_core sith_checker u_sith_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

// File: dv/string_intern_hash_table_core_checker.sv
// Checker for string_intern_hash_table_core: watches request and result ports,
// predicts each result with an FNV-1a linear-probing table model, compares fields.
// Depends on sith_pkg.
module string_intern_hash_table_core_checker #(
    parameter int CAPACITY       = 1024,
    parameter int SLOT_COUNT     = 2048,
    parameter int MAX_NAME_BYTES = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  sith_pkg::t_req i_req,
    input  logic           o_valid,
    input  sith_pkg::t_rsp o_rsp,
    output int             o_fail_count,
    output int             o_pending
);
    import sith_pkg::*;

    logic [7:0]  interned_bytes [CAPACITY][256];
    int          interned_len [CAPACITY];
    int          slot_index [SLOT_COUNT];
    int          next_index;
    logic [7:0]  name_buf [256];
    logic [31:0] name_hash;
    int          name_len;
    t_rsp        expected_rsps [$];

    assign o_pending = expected_rsps.size();

    function automatic bit row_equal(int idx);
        if (idx >= CAPACITY || interned_len[idx] != name_len) return 0;
        for (int i = 0; i < name_len; i++)
            if (interned_bytes[idx][i] != name_buf[i]) return 0;
        return 1;
    endfunction

    task automatic intern_request(t_req rq);
        t_rsp   r;
        int     slot;
        int     probes;
        int     idx;
        logic [31:0] x;
        if (rq.empty_name) begin
            name_hash = HASH_BASIS;
            name_len  = 0;
            r = '{name_index: 10'd0, status: ST_EMPTY};
            expected_rsps.push_back(r);
            return;
        end
        x = name_hash ^ {24'd0, rq.name_byte};
        name_hash = x * HASH_PRIME;
        if (name_len < MAX_NAME_BYTES) begin
            name_buf[name_len] = rq.name_byte;
            name_len++;
        end else begin
            name_len = MAX_NAME_BYTES + 1;
        end
        if (!rq.last_byte) return;
        if (name_len > MAX_NAME_BYTES) begin
            r = '{name_index: 10'd0, status: ST_LONG};
        end else begin
            slot = int'(name_hash % SLOT_COUNT);
            r.status = ST_FULL;
            r.name_index = '0;
            for (probes = 0; probes < SLOT_COUNT; probes++) begin
                idx = slot_index[slot];
                if (idx == 0) break;
                if (row_equal(idx)) begin
                    r.status = ST_FOUND;
                    r.name_index = idx[9:0];
                    break;
                end
                slot = (slot + 1) % SLOT_COUNT;
            end
            if (r.status != ST_FOUND && probes < SLOT_COUNT && next_index < CAPACITY) begin
                idx = next_index;
                for (int i = 0; i < name_len; i++) interned_bytes[idx][i] = name_buf[i];
                interned_len[idx] = name_len;
                next_index++;
                slot_index[slot] = idx;
                r.status = ST_NEW;
                r.name_index = idx[9:0];
            end
        end
        name_hash = HASH_BASIS;
        name_len  = 0;
        expected_rsps.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) slot_index[s] = 0;
            for (int k = 0; k < CAPACITY; k++) interned_len[k] = -1;
            next_index   = 1;
            name_hash    = HASH_BASIS;
            name_len     = 0;
            o_fail_count = 0;
            expected_rsps.delete();
        end else begin
            if (o_valid) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result index=%0d status=%0d",
                             $time, o_rsp.name_index, o_rsp.status);
                    o_fail_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want.name_index !== o_rsp.name_index) begin
                        $display("%0t: name_index expected %0d actual %0d",
                                 $time, want.name_index, o_rsp.name_index);
                        o_fail_count++;
                    end
                    if (want.status !== o_rsp.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_rsp.status);
                        o_fail_count++;
                    end
                end
            end
            if (start && !busy) intern_request(i_req);
        end
    end
endmodule

// File: dv/string_intern_hash_table_core_tb.sv
// Testbench top for string_intern_hash_table_core: drives byte-serial name requests
// in random bursts (short names, repeats, long and empty names) and gives the verdict.
// Depends on sith_pkg, the block and string_intern_hash_table_core_checker.
module string_intern_hash_table_core_tb;
    import sith_pkg::*;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    t_req   i_req;
    logic   busy;
    logic   o_valid;
    t_rsp   o_rsp;
    int     fail_count;
    int     pending;
    int     burst_left;
    int     sent_names;
    int     sent_items;
    logic [7:0] seen_names [$][$];

    string_intern_hash_table_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(i_req),
        .busy(busy), .o_valid(o_valid), .o_rsp(o_rsp)
    );

    string_intern_hash_table_core_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_valid(o_valid), .o_rsp(o_rsp), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic send_request(logic [7:0] b, logic lst, logic emp);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        sent_items++;
        start <= 1'b1;
        i_req <= '{name_byte: b, last_byte: lst, empty_name: emp};
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_name(logic [7:0] nm [$]);
        for (int i = 0; i < nm.size(); i++)
            send_request(nm[i], i == nm.size() - 1, 1'b0);
        sent_names++;
    endtask

    task automatic send_random_name(int len);
        logic [7:0] nm [$];
        for (int i = 0; i < len; i++) nm.push_back(8'($urandom));
        seen_names.push_back(nm);
        send_name(nm);
    endtask

    initial begin
        logic [7:0] nm [$];
        int pick;
        start      = 1'b0;
        i_req      = '0;
        i_rst_n    = 1'b0;
        burst_left = 0;
        sent_names = 0;
        sent_items = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h41, 1'b0, 1'b0);
        send_request(8'h42, 1'b0, 1'b1);
        send_request(8'hA5, 1'b1, 1'b1);
        send_request(8'h5A, 1'b0, 1'b0);
        send_request(8'h5A, 1'b1, 1'b0);
        send_request(8'h5A, 1'b0, 1'b0);
        send_request(8'h5A, 1'b1, 1'b0);
        nm.delete();
        for (int i = 0; i < 255; i++) nm.push_back(8'(i));
        send_name(nm);
        send_name(nm);
        nm.push_back(8'h77);
        send_name(nm);

        drain();

        while (sent_items < 850) begin
            pick = $urandom_range(0, 99);
            if (pick < 50 || seen_names.size() == 0)
                send_random_name($urandom_range(1, 4));
            else if (pick < 82)
                send_name(seen_names[$urandom_range(0, seen_names.size() - 1)]);
            else if (pick < 92)
                send_request(8'($urandom), 1'($urandom), 1'b1);
            else
                send_random_name($urandom_range(5, 12));
            if (sent_names == 15) drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("string_intern_hash_table_core_tb: PASS");
        else
            $display("string_intern_hash_table_core_tb: FAIL");
        $finish;
    end

    initial begin
        #20000000;
        $display("string_intern_hash_table_core_tb: FAIL");
        $finish;
    end
endmodule

// File: filelist.f
hdl/sith_pkg.sv
hdl/sith_mod.sv
hdl/string_intern_hash_table_core.sv
hdl/sith_checker.sv
dv/string_intern_hash_table_core_checker.sv
dv/string_intern_hash_table_core_tb.sv
